// ----- sv/sco_pkg.sv -----
package sco_pkg;

    localparam int LEN_W    = 7;
    localparam int OFF_W    = 16;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 17;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    localparam logic REG_MAX_SIZE = 1'b0;

    localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = 17'h10000;

    typedef struct packed {
        logic             op;
        logic [LEN_W-1:0] length;
        logic [OFF_W-1:0] offset;
    } t_req;

    typedef struct packed {
        logic [OFF_W-1:0]    granted_offset;
        logic [LEN_W-1:0]    granted_length;
        logic [STATUS_W-1:0] status;
    } t_rsp;

endpackage

// ----- sv/sco_ram.sv -----
module sco_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    i_clk,
    i_we,
    i_waddr,
    i_wdata,
    i_raddr,
    o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             i_clk;
    input  logic             i_we;
    input  logic [AW-1:0]    i_waddr;
    input  logic [WIDTH-1:0] i_wdata;
    input  logic [AW-1:0]    i_raddr;
    output logic [WIDTH-1:0] o_rdata;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/sco_cfg.sv -----
module sco_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sco_pkg::APB_AW-1:0]  paddr,
    input  logic [sco_pkg::APB_DW-1:0]  pwdata,
    output logic [sco_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic [sco_pkg::SIZE_W-1:0]  o_max_size
);
    import sco_pkg::*;

    logic [SIZE_W-1:0] r_max_size;
    logic              w_wr;
    logic              w_hit;

    assign pready = 1'b1;
    assign w_hit  = (paddr[APB_AW-1] == REG_MAX_SIZE);
    assign w_wr   = psel && penable && pwrite && pready && w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= MAX_SIZE_RESET;
        end else if (w_wr) begin
            r_max_size <= pwdata[SIZE_W-1:0];
        end
    end

    assign prdata     = w_hit ? APB_DW'(r_max_size) : '0;
    assign o_max_size = r_max_size;

endmodule

// ----- sv/size_class_offset_allocator.sv -----
// Channel   | Direction | Handshake               | Beat
// ----------+-----------+-------------------------+----------------------------
// request   | in        | start & !busy           | i_req (op, length, offset)
// result    | out       | o_valid, one cycle      | o_result (offset, length, status)
// config    | in        | psel & penable & pwrite | paddr, pwdata, prdata
//
// A request goes from S_IDLE to S_COUNT and back, by way of S_POP when an allocate pops
// a freed offset: the class count is read from its memory, then the class stack.
// The result beat is registered from the data of the last memory read.
// After reset busy stays high while the class counts are cleared, one class at a time.
// The result channel has no backpressure; a beat is taken in its single cycle.
module size_class_offset_allocator #(
    parameter int MAX_LEN      = 64,
    parameter int STACK_DEPTH  = 256,
    parameter int OFFSET_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  sco_pkg::t_req               i_req,
    output logic                        o_valid,
    output sco_pkg::t_rsp               o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sco_pkg::APB_AW-1:0]  paddr,
    input  logic [sco_pkg::APB_DW-1:0]  pwdata,
    output logic [sco_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import sco_pkg::*;

    localparam int CLS_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int EXT_W   = CLS_W + 8;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W   = $clog2(STACK_DEPTH);
    localparam int STK_N   = MAX_LEN * STACK_DEPTH;
    localparam int STK_AW  = (STK_N > 1) ? $clog2(STK_N) : 1;
    localparam int MUL_W   = STK_AW + 17;
    localparam int LIM_W   = 34;
    localparam int WIDE_W  = 48;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_COUNT = 2'd2;
    localparam logic [1:0] S_POP   = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CLS_W-1:0]  r_clr, n_clr;
    logic [SIZE_W-1:0] r_bump, n_bump;
    logic              r_valid, n_valid;
    t_rsp              r_rsp, n_rsp;
    t_req              r_req;
    logic [CLS_W-1:0]  r_cls;
    logic              r_bad;

    logic [SIZE_W-1:0] w_max_size;
    logic [EXT_W-1:0]  w_len_ext;
    logic [EXT_W-1:0]  w_len_m1;
    logic [CLS_W-1:0]  w_cls;
    logic              w_bad;
    logic              w_accept;

    logic              cnt_we;
    logic [CLS_W-1:0]  cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [CNT_W-1:0]  cnt_rdata;

    logic                    stk_we;
    logic [STK_AW-1:0]       stk_waddr;
    logic [STK_AW-1:0]       stk_raddr;
    logic [OFFSET_WIDTH-1:0] stk_wdata;
    logic [OFFSET_WIDTH-1:0] stk_rdata;

    logic [MUL_W-1:0]  w_base_full;
    logic [STK_AW-1:0] w_base;
    logic [CNT_W-1:0]  w_cnt_m1;
    logic [CNT_W-1:0]  w_cnt_p1;
    logic [LIM_W-1:0]  w_cap;
    logic [LIM_W-1:0]  w_limit;
    logic [LIM_W-1:0]  w_sum;
    logic [LIM_W-1:0]  w_bump_m;
    logic [WIDE_W-1:0] w_off_wide;
    logic [WIDE_W-1:0] w_rd_wide;

    sco_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_max_size (w_max_size)
    );

    sco_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_LEN)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (w_cls),
        .o_rdata (cnt_rdata)
    );

    sco_ram #(
        .WIDTH (OFFSET_WIDTH),
        .DEPTH (STK_N)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_len_ext = EXT_W'(i_req.length);
    assign w_len_m1  = w_len_ext - EXT_W'(1);
    assign w_cls     = w_len_m1[CLS_W-1:0];
    assign w_bad     = (i_req.length == '0) || (w_len_ext > EXT_W'(MAX_LEN));

    assign w_base_full = MUL_W'(r_cls) * MUL_W'(STACK_DEPTH);
    assign w_base      = w_base_full[STK_AW-1:0];
    assign w_cnt_m1    = cnt_rdata - CNT_W'(1);
    assign w_cnt_p1    = cnt_rdata + CNT_W'(1);
    assign stk_raddr   = w_base + STK_AW'(w_cnt_m1[IDX_W-1:0]);

    assign w_cap    = LIM_W'(1) << OFFSET_WIDTH;
    assign w_limit  = (LIM_W'(w_max_size) < w_cap) ? LIM_W'(w_max_size) : w_cap;
    assign w_sum    = LIM_W'(r_bump) + LIM_W'(r_req.length);
    assign w_bump_m = LIM_W'(r_bump) & (w_cap - LIM_W'(1));

    assign w_off_wide = WIDE_W'(r_req.offset);
    assign w_rd_wide  = WIDE_W'(stk_rdata);

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_bump    = r_bump;
        n_valid   = 1'b0;
        n_rsp     = r_rsp;
        cnt_we    = 1'b0;
        cnt_waddr = r_cls;
        cnt_wdata = cnt_rdata;
        stk_we    = 1'b0;
        stk_waddr = w_base + STK_AW'(cnt_rdata[IDX_W-1:0]);
        stk_wdata = w_off_wide[OFFSET_WIDTH-1:0];
        unique case (r_state)
            S_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr;
                cnt_wdata = '0;
                n_clr     = r_clr + CLS_W'(1);
                if (r_clr == CLS_W'(MAX_LEN - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                n_state                    = S_IDLE;
                n_valid                    = 1'b1;
                n_rsp.granted_offset       = '0;
                n_rsp.granted_length       = r_req.length;
                n_rsp.status               = ST_OK;
                if (r_bad) begin
                    n_rsp.status = ST_BAD_LEN;
                end else if (r_req.op == OP_ALLOC) begin
                    if (cnt_rdata != '0) begin
                        n_valid   = 1'b0;
                        n_state   = S_POP;
                        cnt_we    = 1'b1;
                        cnt_wdata = w_cnt_m1;
                    end else if (w_sum > w_limit) begin
                        n_rsp.status = ST_NO_SPACE;
                    end else begin
                        n_rsp.granted_offset = w_bump_m[OFF_W-1:0];
                        n_bump               = w_sum[SIZE_W-1:0];
                    end
                end else begin
                    if (cnt_rdata >= CNT_W'(STACK_DEPTH)) begin
                        n_rsp.status = ST_FULL;
                    end else begin
                        stk_we    = 1'b1;
                        cnt_we    = 1'b1;
                        cnt_wdata = w_cnt_p1;
                    end
                end
            end
            S_POP: begin
                n_state              = S_IDLE;
                n_valid              = 1'b1;
                n_rsp.granted_offset = w_rd_wide[OFF_W-1:0];
                n_rsp.granted_length = r_req.length;
                n_rsp.status         = ST_OK;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_bump  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_bump  <= n_bump;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (w_accept) begin
            r_req <= i_req;
            r_cls <= w_cls;
            r_bad <= w_bad;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_rsp;

endmodule

// ----- test/size_class_offset_allocator_tb.sv -----
`timescale 1ns / 1ps

module size_class_offset_allocator_tb;
    import sco_pkg::*;

    localparam int MAX_LEN      = 64;
    localparam int STACK_DEPTH  = 256;
    localparam int OFFSET_WIDTH = 16;
    localparam int QUIET_LIMIT  = 2000;
    localparam int LEN_TOP      = (1 << LEN_W) - 1;

    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_LEN);
    localparam logic [LEN_W-1:0] LEN_OVER = LEN_W'(MAX_LEN + 1);
    localparam logic [LEN_W-1:0] LEN_ALL1 = LEN_W'(LEN_TOP);

    localparam logic [APB_AW-1:0] ADDR_MAX_SIZE = {REG_MAX_SIZE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_UNUSED   = 3'd4;

    typedef struct {
        logic [OFF_W-1:0] offset;
        logic [LEN_W-1:0] length;
    } t_block;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    t_req               i_req   = '0;
    logic               o_valid;
    t_rsp               o_result;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [APB_AW-1:0]  paddr   = '0;
    logic [APB_DW-1:0]  pwdata  = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    size_class_offset_allocator #(
        .MAX_LEN      (MAX_LEN),
        .STACK_DEPTH  (STACK_DEPTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // allocator state as predicted
    logic [OFF_W-1:0]  freed_offsets [MAX_LEN][STACK_DEPTH];
    int                class_fill [MAX_LEN];
    logic [SIZE_W-1:0] bump_next;
    logic [SIZE_W-1:0] size_limit;

    t_rsp   pending_results [$];
    t_block live_blocks [$];
    int     mismatches;
    int     status_seen [4];
    int     requests_sent;
    int     limit_writes;
    int     quiet_cycles;
    bit     no_idle;

    function automatic t_rsp allocator_outcome(t_req req);
        t_rsp        rsp;
        int          cls;
        int          cnt;
        logic [17:0] ceiling;
        logic [17:0] reach;
        rsp.granted_offset = '0;
        rsp.granted_length = req.length;
        rsp.status         = ST_OK;
        if (req.length == 0 || req.length > MAX_LEN) begin
            rsp.status = ST_BAD_LEN;
            return rsp;
        end
        cls = req.length - 1;
        cnt = class_fill[cls];
        if (req.op == OP_ALLOC) begin
            if (cnt > 0) begin
                cnt--;
                rsp.granted_offset = freed_offsets[cls][cnt];
                class_fill[cls]    = cnt;
            end else begin
                ceiling = (size_limit < 17'h10000) ? {1'b0, size_limit} : 18'h10000;
                reach   = 18'(bump_next) + 18'(req.length);
                if (reach > ceiling) begin
                    rsp.status = ST_NO_SPACE;
                end else begin
                    rsp.granted_offset = bump_next[OFF_W-1:0];
                    bump_next          = reach[SIZE_W-1:0];
                end
            end
        end else if (cnt >= STACK_DEPTH) begin
            rsp.status = ST_FULL;
        end else begin
            freed_offsets[cls][cnt] = req.offset;
            class_fill[cls]         = cnt + 1;
        end
        return rsp;
    endfunction

    function automatic void flag_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
    endfunction

    function automatic int idle_gap();
        int r;
        if ($urandom_range(0, 63) == 0)
            no_idle = !no_idle;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [LEN_W-1:0] random_length();
        if ($urandom_range(0, 1))
            return LEN_W'($urandom_range(1, 4));
        return LEN_W'($urandom_range(1, MAX_LEN));
    endfunction

    task automatic send_req(input logic op, input logic [LEN_W-1:0] len,
                            input logic [OFF_W-1:0] off, output t_rsp rsp);
        t_req req;
        int   gap;
        req.op     = op;
        req.length = len;
        req.offset = off;
        gap = idle_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        rsp = allocator_outcome(req);
        pending_results.push_back(rsp);
        status_seen[rsp.status]++;
        requests_sent++;
        if (op == OP_ALLOC && rsp.status == ST_OK)
            live_blocks.push_back('{offset: rsp.granted_offset, length: len});
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MAX_SIZE) begin
            size_limit = data[SIZE_W-1:0];
            limit_writes++;
        end
    endtask

    task automatic check_limit_readback();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MAX_SIZE;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        if (prdata[SIZE_W-1:0] !== size_limit)
            flag_mismatch("maximum_size readback", int'(size_limit),
                          int'(prdata[SIZE_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_max_size(input logic [SIZE_W-1:0] value);
        logic [APB_DW-1:0] word;
        word = $urandom;
        word[SIZE_W-1:0] = value;
        apb_write(ADDR_MAX_SIZE, word);
        check_limit_readback();
    endtask

    task automatic test_directed_requests();
        t_rsp rsp;
        drain();
        check_limit_readback();
        send_req(OP_ALLOC, 7'd1,     16'hFFFF, rsp);
        send_req(OP_ALLOC, LEN_FULL, 16'h0000, rsp);
        send_req(OP_ALLOC, 7'd0,     16'h0000, rsp);
        send_req(OP_FREE,  LEN_OVER, 16'h1111, rsp);
        send_req(OP_FREE,  LEN_ALL1, 16'hFFFF, rsp);
        send_req(OP_ALLOC, LEN_ALL1, 16'hFFFF, rsp);
        send_req(OP_FREE,  LEN_FULL, 16'hFFFF, rsp);
        send_req(OP_FREE,  7'd1,     16'h0000, rsp);
        send_req(OP_FREE,  LEN_FULL, 16'h1234, rsp);
        send_req(OP_ALLOC, LEN_FULL, 16'h0000, rsp);
        send_req(OP_ALLOC, LEN_FULL, 16'h0000, rsp);
        send_req(OP_ALLOC, LEN_FULL, 16'hFFFF, rsp);
        send_req(OP_ALLOC, 7'd1,     16'h0000, rsp);
        send_req(OP_ALLOC, 7'd1,     16'h0000, rsp);
        send_req(OP_FREE,  7'd33,    16'h5555, rsp);
        send_req(OP_FREE,  7'd2,     16'hAAAA, rsp);
        send_req(OP_ALLOC, 7'd33,    16'h0000, rsp);
        send_req(OP_ALLOC, 7'd2,     16'h0000, rsp);
    endtask

    task automatic test_space_limit();
        t_rsp             rsp;
        logic [LEN_W-1:0] len;
        drain();
        len = LEN_W'(10);
        while (class_fill[len-1] != 0)
            len = LEN_W'(len % MAX_LEN + 1);
        // grant exactly up to the limit, then refuse
        set_max_size(bump_next + SIZE_W'(len));
        send_req(OP_ALLOC, len, OFF_W'($urandom), rsp);
        send_req(OP_ALLOC, len, OFF_W'($urandom), rsp);
        drain();
        set_max_size('0);
        send_req(OP_ALLOC, 7'd1, OFF_W'($urandom), rsp);
        send_req(OP_FREE,  len,  OFF_W'($urandom), rsp);
        send_req(OP_ALLOC, len,  OFF_W'($urandom), rsp);
        drain();
        apb_write(ADDR_UNUSED, $urandom);
        check_limit_readback();
    endtask

    task automatic test_class_overflow();
        t_rsp             rsp;
        logic [LEN_W-1:0] len;
        drain();
        set_max_size(MAX_SIZE_RESET);
        len = LEN_W'($urandom_range(1, MAX_LEN));
        while (class_fill[len-1] < STACK_DEPTH)
            send_req(OP_FREE, len, OFF_W'($urandom), rsp);
        repeat (3) send_req(OP_FREE, len, OFF_W'($urandom), rsp);
        repeat (20) send_req(OP_ALLOC, len, OFF_W'($urandom), rsp);
    endtask

    task automatic test_random_traffic(input logic [SIZE_W-1:0] limit, input int count);
        t_rsp             rsp;
        int               r;
        int               pick;
        logic             op;
        logic [LEN_W-1:0] len;
        logic [OFF_W-1:0] off;
        drain();
        set_max_size(limit);
        repeat (count) begin
            r   = $urandom_range(0, 99);
            off = OFF_W'($urandom);
            op  = 1'($urandom);
            if (r < 6) begin
                len = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(MAX_LEN + 1, LEN_TOP));
            end else if (r < 50 && live_blocks.size() > 0) begin
                pick = $urandom_range(0, live_blocks.size() - 1);
                op   = OP_FREE;
                off  = live_blocks[pick].offset;
                len  = live_blocks[pick].length;
                live_blocks.delete(pick);
            end else if (r < 55) begin
                op  = OP_FREE;
                len = random_length();
            end else begin
                op  = OP_ALLOC;
                len = random_length();
            end
            send_req(op, len, off, rsp);
        end
    endtask

    task automatic test_exhaust_space();
        t_rsp rsp;
        drain();
        set_max_size('1);
        do send_req(OP_ALLOC, LEN_FULL, OFF_W'($urandom), rsp);
        while (rsp.status != ST_NO_SPACE);
        do send_req(OP_ALLOC, 7'd1, OFF_W'($urandom), rsp);
        while (rsp.status != ST_NO_SPACE);
        test_random_traffic(MAX_SIZE_RESET, 150);
    endtask

    always @(posedge i_clk) begin : check_results
        t_rsp want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result beat", 0, int'(o_result));
            end else begin
                want = pending_results.pop_front();
                if (o_result.granted_offset !== want.granted_offset)
                    flag_mismatch("granted_offset", int'(want.granted_offset),
                                  int'(o_result.granted_offset));
                if (o_result.granted_length !== want.granted_length)
                    flag_mismatch("granted_length", int'(want.granted_length),
                                  int'(o_result.granted_length));
                if (o_result.status !== want.status)
                    flag_mismatch("status", int'(want.status), int'(o_result.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1 || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("size_class_offset_allocator_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < MAX_LEN; i++)
            class_fill[i] = 0;
        bump_next     = '0;
        size_limit    = MAX_SIZE_RESET;
        mismatches    = 0;
        requests_sent = 0;
        limit_writes  = 0;
        quiet_cycles  = 0;
        no_idle       = 1'b0;
        status_seen   = '{default: 0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_requests();
        test_space_limit();
        test_class_overflow();
        test_random_traffic('1, 250);
        test_random_traffic(SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1)), 150);
        test_random_traffic(SIZE_W'(32'(bump_next) + $urandom_range(0, 400)), 250);
        test_random_traffic(MAX_SIZE_RESET, 250);
        test_random_traffic('0, 80);
        test_exhaust_space();
        drain();
        repeat (8) @(posedge i_clk);

        $display("ran %0d requests: %0d ok, %0d out of space, %0d bad length, %0d full class",
                 requests_sent, status_seen[ST_OK], status_seen[ST_NO_SPACE],
                 status_seen[ST_BAD_LEN], status_seen[ST_FULL]);
        $display("bump pointer ended at %0d after %0d limit register writes, %0d mismatches",
                 bump_next, limit_writes, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("size_class_offset_allocator_tb passed");
        end else begin
            $display("size_class_offset_allocator_tb failed");
        end
        $finish;
    end

endmodule
